[sv/cscnt_pkg.sv]
// Shared types, constants and the month length table of the calendar counter.
package cscnt_pkg;

  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 7;

  localparam logic [SecW-1:0]   SecPerMin  = SecW'(60);
  localparam logic [MinW-1:0]   MinPerHour = MinW'(60);
  localparam logic [HourW-1:0]  HourPerDay = HourW'(24);
  localparam logic [MonthW-1:0] MonthLast  = MonthW'(12);
  localparam logic [YearW-1:0]  YearLast   = YearW'(99);

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SecW-1:0]   load_second;
    logic [MinW-1:0]   load_minute;
    logic [HourW-1:0]  load_hour;
    logic [DayW-1:0]   load_day;
    logic [MonthW-1:0] load_month;
    logic [YearW-1:0]  load_year;
  } req_t;

  typedef struct packed {
    logic [SecW-1:0]   second;
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } clk_state_t;

  localparam clk_state_t StateReset = '{
    second: '0, minute: '0, hour: '0,
    day: DayW'(1), month: MonthW'(1), year: '0
  };

  // days in the month; leap February every fourth year, unknown months 31
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] month,
                                                logic [YearW-1:0] year);
    logic [DayW-1:0] len;
    len = DayW'(31);
    unique case (month) inside
      MonthW'(4), MonthW'(6), MonthW'(9), MonthW'(11): len = DayW'(30);
      MonthW'(2): len = (year[1:0] == 2'b00) ? DayW'(29) : DayW'(28);
      default: len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

[sv/cscnt_if.sv]
// Request and result channel interfaces of the calendar counter.
interface cscnt_req_if;
  import cscnt_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [SecW-1:0]   load_second;
  logic [MinW-1:0]   load_minute;
  logic [HourW-1:0]  load_hour;
  logic [DayW-1:0]   load_day;
  logic [MonthW-1:0] load_month;
  logic [YearW-1:0]  load_year;

  modport source (
    output valid, func, load_second, load_minute, load_hour, load_day,
    load_month, load_year,
    input  ready
  );
  modport sink (
    input  valid, func, load_second, load_minute, load_hour, load_day,
    load_month, load_year,
    output ready
  );
endinterface

interface cscnt_rsp_if;
  import cscnt_pkg::*;
  logic              valid;
  logic              ready;
  logic [SecW-1:0]   second_now;
  logic [MinW-1:0]   minute_now;
  logic [HourW-1:0]  hour_now;
  logic [DayW-1:0]   day_now;
  logic [MonthW-1:0] month_now;
  logic [YearW-1:0]  year_now;

  modport source (
    output valid, second_now, minute_now, hour_now, day_now, month_now,
    year_now,
    input  ready
  );
  modport sink (
    input  valid, second_now, minute_now, hour_now, day_now, month_now,
    year_now,
    output ready
  );
endinterface

[sv/cscnt_step.sv]
// Next clock state: load, or one-second advance with carry through the calendar.
module cscnt_step (
  input  cscnt_pkg::clk_state_t cur_i,
  input  cscnt_pkg::req_t       req_i,
  output cscnt_pkg::clk_state_t nxt_o
);
  import cscnt_pkg::*;

  logic [SecW:0]   sec_inc;
  logic [MinW:0]   min_inc;
  logic [HourW:0]  hour_inc;
  logic [DayW:0]   day_inc;
  logic [MonthW:0] month_inc;
  logic [YearW:0]  year_inc;
  logic [DayW-1:0] day_lim;
  logic            sec_c, min_c, hour_c, day_c, month_c;
  clk_state_t      tick;

  assign sec_inc   = {1'b0, cur_i.second} + (SecW+1)'(1);
  assign min_inc   = {1'b0, cur_i.minute} + (MinW+1)'(1);
  assign hour_inc  = {1'b0, cur_i.hour} + (HourW+1)'(1);
  assign day_inc   = {1'b0, cur_i.day} + (DayW+1)'(1);
  assign month_inc = {1'b0, cur_i.month} + (MonthW+1)'(1);
  assign year_inc  = {1'b0, cur_i.year} + (YearW+1)'(1);
  assign day_lim   = month_len(cur_i.month, cur_i.year);

  assign sec_c   = sec_inc >= {1'b0, SecPerMin};
  assign min_c   = sec_c && (min_inc >= {1'b0, MinPerHour});
  assign hour_c  = min_c && (hour_inc >= {1'b0, HourPerDay});
  assign day_c   = hour_c && (day_inc > {1'b0, day_lim});
  assign month_c = day_c && (month_inc > {1'b0, MonthLast});

  always_comb begin
    tick = cur_i;
    tick.second = sec_c ? '0 : sec_inc[SecW-1:0];
    if (sec_c) begin
      tick.minute = min_c ? '0 : min_inc[MinW-1:0];
    end
    if (min_c) begin
      tick.hour = hour_c ? '0 : hour_inc[HourW-1:0];
    end
    if (hour_c) begin
      tick.day = day_c ? DayW'(1) : day_inc[DayW-1:0];
    end
    if (day_c) begin
      tick.month = month_c ? MonthW'(1) : month_inc[MonthW-1:0];
    end
    if (month_c) begin
      tick.year = (year_inc > {1'b0, YearLast}) ? '0 : year_inc[YearW-1:0];
    end
  end

  always_comb begin
    if (req_i.func == FUNC_LOAD) begin
      nxt_o = '{
        second: req_i.load_second, minute: req_i.load_minute,
        hour: req_i.load_hour, day: req_i.load_day,
        month: req_i.load_month, year: req_i.load_year
      };
    end else begin
      nxt_o = tick;
    end
  end

endmodule

[sv/calendar_second_counter.sv]
// Calendar clock top level: request register, step logic, state and result register.
// Requests wait in the request register; results are offered from the state register.
// Throughput: one request per cycle while results are taken; step carry chain sets the path.
// Results wait in the state register; requests keep flowing while it is taken.
// Reset (async, active low) sets 00:00:00, day 1, month 1, year 0 and empties both stages.
module calendar_second_counter (
  input  logic               clk_i,
  input  logic               rst_ni,
  cscnt_req_if.sink          req_i,
  cscnt_rsp_if.source        rsp_o
);
  import cscnt_pkg::*;

  logic       in_valid_q;
  req_t       in_req_q;
  clk_state_t state_q, state_d;
  logic       out_valid_q;
  logic       adv;
  req_t       req_in;

  assign adv         = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || adv;

  assign req_in = '{
    func: req_i.func, load_second: req_i.load_second,
    load_minute: req_i.load_minute, load_hour: req_i.load_hour,
    load_day: req_i.load_day, load_month: req_i.load_month,
    load_year: req_i.load_year
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_req_q <= req_in;
    end
  end

  cscnt_step u_step (
    .cur_i (state_q),
    .req_i (in_req_q),
    .nxt_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.second_now = state_q.second;
  assign rsp_o.minute_now = state_q.minute;
  assign rsp_o.hour_now   = state_q.hour;
  assign rsp_o.day_now    = state_q.day;
  assign rsp_o.month_now  = state_q.month;
  assign rsp_o.year_now   = state_q.year;

  // held request stays put until it moves on
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_req_q))
    else $error("request register lost its contents");

  // a tick leaves seconds in range
  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (in_req_q.func == FUNC_TICK) |=> state_q.second < SecPerMin)
    else $error("seconds out of range after tick");

  // plain second increment leaves the minute and day unchanged
  a_sec_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (in_req_q.func == FUNC_TICK) && (state_q.second < SecW'(59))
    |=> (state_q.second == $past(state_q.second) + SecW'(1))
        && (state_q.minute == $past(state_q.minute))
        && (state_q.day == $past(state_q.day)))
    else $error("bad second increment");

  // a pending result is not overwritten
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> out_valid_q && $stable(state_q))
    else $error("result changed while stalled");

endmodule
